@@ hdl/bfu_pkg.sv @@
// Shared types, constants and saturation helpers for the boid flocking update block.
// Used by bfu_front, bfu_div, bfu_sqrt, bfu_back and boid_flocking_update. No dependencies.
package bfu_pkg;

  // Box bounds in whole units and the neighbour limit per group.
  localparam int X_MIN = -512;
  localparam int X_MAX = 512;
  localparam int Y_MIN = -512;
  localparam int Y_MAX = 512;
  localparam int MAX_NEIGHBOURS = 64;

  localparam int CNT_W = 7;
  localparam int REG_W = 31;
  localparam int CFG_IDX_W = 3;

  localparam longint ONE_Q = 65536;
  localparam logic signed [63:0] X_LO = 64'(longint'(X_MIN) * ONE_Q);
  localparam logic signed [63:0] X_HI = 64'(longint'(X_MAX) * ONE_Q);
  localparam logic signed [63:0] Y_LO = 64'(longint'(Y_MIN) * ONE_Q);
  localparam logic signed [63:0] Y_HI = 64'(longint'(Y_MAX) * ONE_Q);

  localparam logic [CFG_IDX_W-1:0] REG_ALIGNMENT_GAIN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEPARATION_GAIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COHESION_GAIN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPACE_RADIUS    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CRUISE_SPEED    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BOOST_SPEED     = 3'd5;

  localparam logic OP_OWN       = 1'b0;
  localparam logic OP_NEIGHBOUR = 1'b1;

  typedef struct packed {
    logic              op;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic              last;
    logic              key_up;
    logic              key_down;
    logic              key_boost;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] new_pos_x;
    logic signed [31:0] new_pos_y;
    logic signed [31:0] new_pos_z;
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
    logic signed [31:0] new_vel_z;
  } out_item_t;

  typedef enum logic [1:0] {
    KIND_OWN  = 2'd0,
    KIND_ADD  = 2'd1,
    KIND_SKIP = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t    kind;
    in_item_t item;
  } q_entry_t;

  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_head_t;

  typedef struct packed {
    logic [REG_W-1:0] alignment_gain;
    logic [REG_W-1:0] separation_gain;
    logic [REG_W-1:0] cohesion_gain;
    logic [REG_W-1:0] space_radius;
    logic [REG_W-1:0] cruise_speed;
    logic [REG_W-1:0] boost_speed;
  } cfg_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    else if (v < -64'sd2147483648) return 32'sh80000000;
    else return v[31:0];
  endfunction

  function automatic logic signed [39:0] sat40(input logic signed [63:0] v);
    if (v > 64'sd549755813887) return 40'sh7fffffffff;
    else if (v < -64'sd549755813888) return 40'sh8000000000;
    else return v[39:0];
  endfunction

endpackage

@@ hdl/bfu_front.sv @@
// Input side: accepts items, tags each as own record, counted neighbour or dropped
// neighbour, and holds them in a two-entry queue. Depends on bfu_pkg.
module bfu_front import bfu_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  in_item_t in_item,
  input  logic     q_pop,
  output logic     busy,
  output q_head_t  q_head
);

  q_entry_t           fifo_r [2];
  logic               wr_ptr_r, rd_ptr_r;
  logic [1:0]         fill_r, fill_nxt;
  logic [CNT_W-1:0]   grp_cnt_r, grp_cnt_nxt;
  q_entry_t           entry_nxt;
  logic               push;

  assign busy = (fill_r == 2'd2);
  assign push = start && !busy;
  assign fill_nxt = fill_r + 2'(push) - 2'(q_pop);

  // Mirror the group's neighbour count so overflow records are tagged here.
  always_comb begin
    entry_nxt.item = in_item;
    entry_nxt.kind = KIND_SKIP;
    grp_cnt_nxt = grp_cnt_r;
    if (in_item.op == OP_OWN) begin
      entry_nxt.kind = KIND_OWN;
      grp_cnt_nxt = '0;
    end else if (grp_cnt_r < CNT_W'(MAX_NEIGHBOURS)) begin
      entry_nxt.kind = KIND_ADD;
      grp_cnt_nxt = grp_cnt_r + 1'b1;
    end
    if (in_item.last) grp_cnt_nxt = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r <= '0;
      grp_cnt_r <= '0;
    end else begin
      fill_r <= fill_nxt;
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
        grp_cnt_r <= grp_cnt_nxt;
      end
      if (q_pop) rd_ptr_r <= !rd_ptr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) fifo_r[wr_ptr_r] <= entry_nxt;
  end

  assign q_head.valid = (fill_r != 2'd0);
  assign q_head.entry = fifo_r[rd_ptr_r];

`ifndef NO_ASSERTIONS
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> fill_r != 2'd0) else $error("queue popped while empty");
`endif

endmodule

@@ hdl/bfu_div.sv @@
// Shared restoring divider, one quotient bit per cycle, unsigned operands.
// The caller gives how many quotient bits to produce. Depends on bfu_pkg.
module bfu_div import bfu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  input  logic [6:0]  iters,
  output logic        done,
  output logic [63:0] quotient
);

  logic        busy_r, done_r;
  logic [6:0]  cnt_r;
  logic [31:0] rem_r, dsr_r;
  logic [63:0] dvd_r, quo_r;
  logic [32:0] trial;
  logic        ge;

  assign trial = {rem_r, dvd_r[63]};
  assign ge = (trial >= {1'b0, dsr_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
        cnt_r <= iters;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == 7'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Quotient is known to fit in iters bits, so the skipped top bits start the remainder.
  always_ff @(posedge clk) begin
    if (go) begin
      rem_r <= 32'(dividend >> iters);
      dvd_r <= dividend << (7'd64 - iters);
      dsr_r <= divisor;
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? 32'(trial - {1'b0, dsr_r}) : trial[31:0];
      dvd_r <= dvd_r << 1;
      quo_r <= {quo_r[62:0], ge};
    end
  end

  assign done = done_r;
  assign quotient = quo_r;

`ifndef NO_ASSERTIONS
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    go |-> !busy_r) else $error("divider started while busy");
`endif

endmodule

@@ hdl/bfu_sqrt.sv @@
// Shared integer square root, two radicand bits per cycle.
// Floor root of a 64-bit unsigned value. Depends on bfu_pkg.
module bfu_sqrt import bfu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  logic [63:0] radicand,
  output logic        done,
  output logic [31:0] root
);

  logic        busy_r, done_r;
  logic [5:0]  cnt_r;
  logic [63:0] x_r, r_r, b_r;
  logic [64:0] sum;
  logic        take;

  assign sum = {1'b0, r_r} + {1'b0, b_r};
  assign take = ({1'b0, x_r} >= sum);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
        cnt_r <= 6'd32;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      x_r <= radicand;
      r_r <= '0;
      b_r <= 64'h4000_0000_0000_0000;
    end else if (busy_r) begin
      if (take) begin
        x_r <= x_r - sum[63:0];
        r_r <= (r_r >> 1) + b_r;
      end else begin
        r_r <= r_r >> 1;
      end
      b_r <= b_r >> 2;
    end
  end

  assign done = done_r;
  assign root = r_r[31:0];

`ifndef NO_ASSERTIONS
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r) else $error("root done held longer than a cycle");
`endif

endmodule

@@ hdl/bfu_back.sv @@
// Execution side: pops tagged items, keeps the boid and group sums, and runs the
// finish sequence on a shared multiplier, bfu_div and bfu_sqrt. Depends on bfu_pkg.
module bfu_back import bfu_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  q_head_t   q_head,
  input  cfg_t      cfg,
  output logic      q_pop,
  output logic      out_valid,
  output out_item_t out_item
);

  typedef enum logic [10:0] {
    ST_IDLE   = 11'b00000000001,
    ST_NMUL   = 11'b00000000010,
    ST_NSQRT  = 11'b00000000100,
    ST_NDIV   = 11'b00000001000,
    ST_FSTART = 11'b00000010000,
    ST_FAVG   = 11'b00000100000,
    ST_FGAIN  = 11'b00001000000,
    ST_FSQ    = 11'b00010000000,
    ST_FSQRT  = 11'b00100000000,
    ST_FNORM  = 11'b01000000000,
    ST_FOUT   = 11'b10000000000
  } state_t;

  localparam logic [1:0] TERM_ALIGN    = 2'd0;
  localparam logic [1:0] TERM_SEPARATE = 2'd1;
  localparam logic [1:0] TERM_COHERE   = 2'd2;

  state_t state_r;

  logic signed [31:0] own_pos_r [3];
  logic signed [31:0] own_vel_r [3];
  logic [2:0]         keys_r;
  logic signed [39:0] vsum_r [3];
  logic signed [39:0] psum_r [3];
  logic signed [39:0] dsum_r [3];
  logic [CNT_W-1:0]   cnt_r;
  logic               last_r;
  logic signed [31:0] d_r [3];
  logic [63:0]        sq_r;
  logic [31:0]        root_r;
  logic signed [51:0] acc_r;
  logic signed [31:0] nv_r [3];
  logic [2:0]         idx_r;
  logic [1:0]         term_r;
  logic [1:0]         ph_r;
  logic signed [63:0] prod_r;
  logic               div_go_r, sqrt_go_r;
  logic [63:0]        div_dvd_r;
  logic [31:0]        div_dsr_r;
  logic [6:0]         div_it_r;
  logic               out_valid_r;
  out_item_t          out_item_r;

  logic               div_done, sqrt_done;
  logic [63:0]        div_q;
  logic [31:0]        sqrt_root;

  logic signed [31:0] pos_in [3];
  logic signed [31:0] vel_in [3];
  logic signed [63:0] dw [3];
  logic signed [63:0] rad_s;
  logic               near;
  logic [1:0]         sel_c;
  logic signed [31:0] term_v;
  logic [REG_W-1:0]   gain_v;
  logic [REG_W-1:0]   speed_v;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  logic signed [63:0] prod_neg, scaled, key_adj, nv_new;
  logic signed [63:0] sum_w, avg_dvd, sep_w, sep_dvd, norm_dvd, q_s;
  logic               neg_sel;
  logic signed [31:0] np [3];

  function automatic logic signed [31:0] clamp_pos(input logic signed [63:0] v,
                                                   input logic signed [63:0] lo,
                                                   input logic signed [63:0] hi);
    if (v <= lo) return lo[31:0];
    else if (v >= hi) return hi[31:0];
    else return v[31:0];
  endfunction

  bfu_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (div_go_r),
    .dividend (div_dvd_r),
    .divisor  (div_dsr_r),
    .iters    (div_it_r),
    .done     (div_done),
    .quotient (div_q)
  );

  bfu_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (sqrt_go_r),
    .radicand (sq_r),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

  assign q_pop = (state_r == ST_IDLE) && q_head.valid;

  assign pos_in[0] = q_head.entry.item.pos_x;
  assign pos_in[1] = q_head.entry.item.pos_y;
  assign pos_in[2] = q_head.entry.item.pos_z;
  assign vel_in[0] = q_head.entry.item.vel_x;
  assign vel_in[1] = q_head.entry.item.vel_y;
  assign vel_in[2] = q_head.entry.item.vel_z;

  // Offset from the neighbour to the boid and the box test against the radius.
  assign rad_s = $signed({33'b0, cfg.space_radius});
  always_comb begin
    near = 1'b1;
    for (int i = 0; i < 3; i++) begin
      dw[i] = 64'(own_pos_r[i]) - 64'(pos_in[i]);
      if (dw[i] >= rad_s || -dw[i] >= rad_s) near = 1'b0;
    end
  end

  assign sel_c = (state_r == ST_FAVG && idx_r >= 3'd3) ? 2'(idx_r - 3'd3) : idx_r[1:0];

  always_comb begin
    case (term_r)
      TERM_ALIGN: begin
        term_v = sat32(64'(vsum_r[sel_c]) - 64'(own_vel_r[sel_c]));
        gain_v = cfg.alignment_gain;
      end
      TERM_SEPARATE: begin
        term_v = sat32(64'(dsum_r[sel_c]) - 64'(own_vel_r[sel_c]));
        gain_v = cfg.separation_gain;
      end
      default: begin
        term_v = sat32(64'(psum_r[sel_c]) - 64'(own_pos_r[sel_c]) - 64'(own_vel_r[sel_c]));
        gain_v = cfg.cohesion_gain;
      end
    endcase
  end

  assign speed_v = keys_r[2] ? cfg.boost_speed : cfg.cruise_speed;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_NMUL: begin
        if (idx_r == 3'd3) begin
          mul_a = $signed({2'b0, cfg.space_radius});
          mul_b = $signed({2'b0, cfg.space_radius});
        end else begin
          mul_a = 33'(d_r[sel_c]);
          mul_b = 33'(d_r[sel_c]);
        end
      end
      ST_FGAIN: begin
        mul_a = 33'(term_v);
        mul_b = $signed({2'b0, gain_v});
      end
      ST_FSQ: begin
        mul_a = 33'(nv_r[sel_c]);
        mul_b = 33'(nv_r[sel_c]);
      end
      ST_FNORM: begin
        mul_a = 33'(nv_r[sel_c]);
        mul_b = $signed({2'b0, speed_v});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Gained term, divided by one unit with truncation toward zero.
  assign prod_neg = -prod_r;
  assign scaled = prod_r[63] ? -(prod_neg >>> 16) : (prod_r >>> 16);

  always_comb begin
    key_adj = '0;
    if (sel_c == 2'd1) begin
      if (keys_r[0]) key_adj = key_adj + 64'(ONE_Q);
      if (keys_r[1]) key_adj = key_adj - 64'(ONE_Q);
    end
  end

  assign nv_new = 64'(sat32(64'(own_vel_r[sel_c]) + 64'(acc_r) + scaled + key_adj));

  assign sum_w = (idx_r >= 3'd3) ? 64'(psum_r[sel_c]) : 64'(vsum_r[sel_c]);
  assign avg_dvd = sum_w[63] ? -sum_w : sum_w;
  assign sep_w = 64'(d_r[sel_c]);
  assign sep_dvd = (sep_w[63] ? -sep_w : sep_w) <<< 16;
  assign norm_dvd = prod_r[63] ? prod_neg : prod_r;

  always_comb begin
    unique case (state_r)
      ST_FAVG:  neg_sel = sum_w[63];
      ST_NDIV:  neg_sel = d_r[sel_c][31];
      default:  neg_sel = prod_r[63];
    endcase
  end

  assign q_s = neg_sel ? -$signed(div_q) : $signed(div_q);

  always_comb begin
    np[0] = clamp_pos(64'(own_pos_r[0]) + 64'(nv_r[0]), X_LO, X_HI);
    np[1] = clamp_pos(64'(own_pos_r[1]) + 64'(nv_r[1]), Y_LO, Y_HI);
    np[2] = clamp_pos(64'(own_pos_r[2]) + 64'(nv_r[2]), X_LO, X_HI);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r <= '0;
      term_r <= '0;
      ph_r <= '0;
      div_go_r <= 1'b0;
      sqrt_go_r <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r <= '0;
      keys_r <= '0;
      last_r <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        own_pos_r[i] <= '0;
        own_vel_r[i] <= '0;
        vsum_r[i] <= '0;
        psum_r[i] <= '0;
        dsum_r[i] <= '0;
      end
    end else begin
      div_go_r <= 1'b0;
      sqrt_go_r <= 1'b0;
      out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (q_head.valid) begin
            unique case (q_head.entry.kind)
              KIND_OWN: begin
                for (int i = 0; i < 3; i++) begin
                  own_pos_r[i] <= pos_in[i];
                  own_vel_r[i] <= vel_in[i];
                  vsum_r[i] <= '0;
                  psum_r[i] <= '0;
                  dsum_r[i] <= '0;
                end
                keys_r <= {q_head.entry.item.key_boost, q_head.entry.item.key_down,
                           q_head.entry.item.key_up};
                cnt_r <= '0;
                if (q_head.entry.item.last) state_r <= ST_FSTART;
              end
              KIND_ADD: begin
                for (int i = 0; i < 3; i++) begin
                  vsum_r[i] <= sat40(64'(vsum_r[i]) + 64'(vel_in[i]));
                  psum_r[i] <= sat40(64'(psum_r[i]) + 64'(pos_in[i]));
                  d_r[i] <= dw[i][31:0];
                end
                cnt_r <= cnt_r + 1'b1;
                last_r <= q_head.entry.item.last;
                if (near) begin
                  idx_r <= '0;
                  ph_r <= '0;
                  sq_r <= '0;
                  state_r <= ST_NMUL;
                end else if (q_head.entry.item.last) begin
                  state_r <= ST_FSTART;
                end
              end
              default: begin
                if (q_head.entry.item.last) state_r <= ST_FSTART;
              end
            endcase
          end
        end
        ST_NMUL: begin
          if (ph_r == 2'd0) begin
            prod_r <= mul_p[63:0];
            ph_r <= 2'd1;
          end else begin
            ph_r <= 2'd0;
            if (idx_r != 3'd3) begin
              sq_r <= sq_r + $unsigned(prod_r);
              idx_r <= idx_r + 1'b1;
            end else if (sq_r != 64'd0 && sq_r < $unsigned(prod_r)) begin
              sqrt_go_r <= 1'b1;
              state_r <= ST_NSQRT;
            end else begin
              state_r <= last_r ? ST_FSTART : ST_IDLE;
            end
          end
        end
        ST_NSQRT: begin
          if (sqrt_done) begin
            root_r <= sqrt_root;
            idx_r <= '0;
            ph_r <= '0;
            state_r <= ST_NDIV;
          end
        end
        ST_NDIV: begin
          if (ph_r == 2'd0) begin
            div_go_r <= 1'b1;
            div_dvd_r <= sep_dvd;
            div_dsr_r <= root_r;
            div_it_r <= 7'd17;
            ph_r <= 2'd1;
          end else if (div_done) begin
            dsum_r[sel_c] <= sat40(64'(dsum_r[sel_c]) + q_s);
            ph_r <= 2'd0;
            if (idx_r == 3'd2) state_r <= last_r ? ST_FSTART : ST_IDLE;
            else idx_r <= idx_r + 1'b1;
          end
        end
        ST_FSTART: begin
          idx_r <= '0;
          ph_r <= '0;
          if (cnt_r == '0) begin
            for (int i = 0; i < 3; i++) nv_r[i] <= own_vel_r[i];
            sq_r <= '0;
            state_r <= ST_FSQ;
          end else begin
            state_r <= ST_FAVG;
          end
        end
        ST_FAVG: begin
          if (ph_r == 2'd0) begin
            div_go_r <= 1'b1;
            div_dvd_r <= avg_dvd;
            div_dsr_r <= 32'(cnt_r);
            div_it_r <= 7'd40;
            ph_r <= 2'd1;
          end else if (div_done) begin
            // Overwrite each sum with its average; the group is cleared after output.
            if (idx_r >= 3'd3) psum_r[sel_c] <= q_s[39:0];
            else vsum_r[sel_c] <= q_s[39:0];
            ph_r <= 2'd0;
            if (idx_r == 3'd5) begin
              idx_r <= '0;
              term_r <= TERM_ALIGN;
              acc_r <= '0;
              state_r <= ST_FGAIN;
            end else begin
              idx_r <= idx_r + 1'b1;
            end
          end
        end
        ST_FGAIN: begin
          if (ph_r == 2'd0) begin
            prod_r <= mul_p[63:0];
            ph_r <= 2'd1;
          end else begin
            ph_r <= 2'd0;
            if (term_r != TERM_COHERE) begin
              acc_r <= acc_r + scaled[51:0];
              term_r <= term_r + 1'b1;
            end else begin
              nv_r[sel_c] <= nv_new[31:0];
              acc_r <= '0;
              term_r <= TERM_ALIGN;
              if (idx_r == 3'd2) begin
                idx_r <= '0;
                sq_r <= '0;
                state_r <= ST_FSQ;
              end else begin
                idx_r <= idx_r + 1'b1;
              end
            end
          end
        end
        ST_FSQ: begin
          if (ph_r == 2'd0) begin
            prod_r <= mul_p[63:0];
            ph_r <= 2'd1;
          end else begin
            ph_r <= 2'd0;
            sq_r <= sq_r + $unsigned(prod_r);
            if (idx_r == 3'd2) begin
              sqrt_go_r <= 1'b1;
              state_r <= ST_FSQRT;
            end else begin
              idx_r <= idx_r + 1'b1;
            end
          end
        end
        ST_FSQRT: begin
          if (sqrt_done) begin
            root_r <= sqrt_root;
            idx_r <= '0;
            ph_r <= '0;
            if (sqrt_root == 32'd0) begin
              for (int i = 0; i < 3; i++) nv_r[i] <= '0;
              state_r <= ST_FOUT;
            end else begin
              state_r <= ST_FNORM;
            end
          end
        end
        ST_FNORM: begin
          if (ph_r == 2'd0) begin
            prod_r <= mul_p[63:0];
            ph_r <= 2'd1;
          end else if (ph_r == 2'd1) begin
            div_go_r <= 1'b1;
            div_dvd_r <= norm_dvd;
            div_dsr_r <= root_r;
            div_it_r <= 7'd31;
            ph_r <= 2'd2;
          end else if (div_done) begin
            nv_r[sel_c] <= q_s[31:0];
            ph_r <= 2'd0;
            if (idx_r == 3'd2) state_r <= ST_FOUT;
            else idx_r <= idx_r + 1'b1;
          end
        end
        ST_FOUT: begin
          out_item_r.new_pos_x <= np[0];
          out_item_r.new_pos_y <= np[1];
          out_item_r.new_pos_z <= np[2];
          out_item_r.new_vel_x <= nv_r[0];
          out_item_r.new_vel_y <= nv_r[1];
          out_item_r.new_vel_z <= nv_r[2];
          out_valid_r <= 1'b1;
          for (int i = 0; i < 3; i++) begin
            vsum_r[i] <= '0;
            psum_r[i] <= '0;
            dsum_r[i] <= '0;
          end
          cnt_r <= '0;
          state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_item = out_item_r;

`ifndef NO_ASSERTIONS
  a_out_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r) else $error("result strobe held longer than a cycle");
`endif

endmodule

@@ hdl/boid_flocking_update.sv @@
// Boid flocking update top level: configuration registers, input queue and execution.
// Results are strobed for one cycle and cannot be held off. Synchronous active-low reset
// restores the register defaults and clears the boid record, sums and queue.
module boid_flocking_update import bfu_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  in_item_t             in_item,
  output logic                 out_valid,
  output out_item_t            out_item,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_data
);

  cfg_t    cfg_r;
  q_head_t q_head;
  logic    q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.alignment_gain <= 31'd65536;
      cfg_r.separation_gain <= 31'd65536;
      cfg_r.cohesion_gain <= 31'd65536;
      cfg_r.space_radius <= 31'd655360;
      cfg_r.cruise_speed <= 31'd65536;
      cfg_r.boost_speed <= 31'd131072;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ALIGNMENT_GAIN:  cfg_r.alignment_gain <= cfg_data;
        REG_SEPARATION_GAIN: cfg_r.separation_gain <= cfg_data;
        REG_COHESION_GAIN:   cfg_r.cohesion_gain <= cfg_data;
        REG_SPACE_RADIUS:    cfg_r.space_radius <= cfg_data;
        REG_CRUISE_SPEED:    cfg_r.cruise_speed <= cfg_data;
        REG_BOOST_SPEED:     cfg_r.boost_speed <= cfg_data;
        default: ;
      endcase
    end
  end

  bfu_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_item (in_item),
    .q_pop   (q_pop),
    .busy    (busy),
    .q_head  (q_head)
  );

  bfu_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_head    (q_head),
    .cfg       (cfg_r),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

@@ tb/boid_flocking_update_tb.sv @@
// Self-checking testbench for boid_flocking_update: directed table, then random boid groups.
// Depends on bfu_pkg and the boid_flocking_update RTL; the expected-result model is built in.
module boid_flocking_update_tb;
  import bfu_pkg::*;

  localparam longint QONE = 65536;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int DRAIN_CYCLES = 600;
  localparam int RANDOM_ITEMS = 1650;
  localparam int NUM_PHASES = 6;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_item_t in_item = '0;
  logic out_valid;
  out_item_t out_item;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [REG_W-1:0] cfg_data = '0;

  boid_flocking_update u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Flocking state as seen by the checker
  longint gain_align, gain_sep, gain_coh, radius, speed_cruise, speed_boost;
  longint boid_pos[3], boid_vel[3], vel_acc[3], pos_acc[3], sep_acc[3];
  int nb_count;
  logic [2:0] boid_keys;

  out_item_t pending_updates[$];
  int n_errors = 0;
  int n_results = 0;
  int n_items = 0;
  int n_groups = 0;
  longint cycles = 0;

  function automatic longint clip(longint v, longint lo, longint hi);
    if (v <= lo) return lo;
    if (v >= hi) return hi;
    return v;
  endfunction

  function automatic longint s32(longint v);
    return clip(v, -64'sd2147483648, 64'sd2147483647);
  endfunction

  function automatic longint s40(longint v);
    return clip(v, -64'sd549755813888, 64'sd549755813887);
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Queue one expected update at the tail
  function automatic void expect_update(out_item_t u);
    pending_updates = {pending_updates, u};
  endfunction

  function automatic void drop_group();
    for (int i = 0; i < 3; i++) begin
      vel_acc[i] = 0;
      pos_acc[i] = 0;
      sep_acc[i] = 0;
    end
    nb_count = 0;
  endfunction

  function automatic void reset_flock();
    gain_align = QONE;
    gain_sep = QONE;
    gain_coh = QONE;
    radius = 10 * QONE;
    speed_cruise = QONE;
    speed_boost = 2 * QONE;
    for (int i = 0; i < 3; i++) begin
      boid_pos[i] = 0;
      boid_vel[i] = 0;
    end
    boid_keys = '0;
    drop_group();
  endfunction

  function automatic void absorb_neighbour(longint p[3], longint v[3]);
    longint d[3];
    longint sep_len;
    longint unsigned sq;
    bit near;
    near = 1'b1;
    sq = 0;
    for (int i = 0; i < 3; i++) begin
      vel_acc[i] = s40(vel_acc[i] + v[i]);
      pos_acc[i] = s40(pos_acc[i] + p[i]);
      d[i] = boid_pos[i] - p[i];
      if (d[i] >= radius || -d[i] >= radius) near = 1'b0;
    end
    if (near) begin
      for (int i = 0; i < 3; i++) sq += longint'(d[i] * d[i]);
      if (sq > 0 && sq < longint'(radius * radius)) begin
        sep_len = longint'(floor_sqrt(sq));
        for (int i = 0; i < 3; i++) sep_acc[i] = s40(sep_acc[i] + (d[i] * QONE) / sep_len);
      end
    end
    nb_count++;
  endfunction

  function automatic out_item_t steer_boid();
    longint nv[3], np[3];
    longint acc, n, a, s, c, speed, mag, lo, hi;
    longint unsigned sq;
    out_item_t r;
    sq = 0;
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      if (nb_count > 0) begin
        n = nb_count;
        a = s32(vel_acc[i] / n - boid_vel[i]);
        s = s32(sep_acc[i] - boid_vel[i]);
        c = s32(pos_acc[i] / n - boid_pos[i] - boid_vel[i]);
        acc = (a * gain_align) / QONE + (s * gain_sep) / QONE + (c * gain_coh) / QONE;
        if (i == 1) begin
          if (boid_keys[0]) acc += QONE;
          if (boid_keys[1]) acc -= QONE;
        end
      end
      nv[i] = s32(boid_vel[i] + acc);
      sq += longint'(nv[i] * nv[i]);
    end
    speed = boid_keys[2] ? speed_boost : speed_cruise;
    mag = longint'(floor_sqrt(sq));
    for (int i = 0; i < 3; i++) begin
      nv[i] = (mag == 0) ? 0 : (nv[i] * speed) / mag;
      lo = (i == 1) ? longint'(Y_MIN) * QONE : longint'(X_MIN) * QONE;
      hi = (i == 1) ? longint'(Y_MAX) * QONE : longint'(X_MAX) * QONE;
      np[i] = clip(boid_pos[i] + nv[i], lo, hi);
    end
    r.new_pos_x = np[0][31:0];
    r.new_pos_y = np[1][31:0];
    r.new_pos_z = np[2][31:0];
    r.new_vel_x = nv[0][31:0];
    r.new_vel_y = nv[1][31:0];
    r.new_vel_z = nv[2][31:0];
    return r;
  endfunction

  // Advance the model by one accepted item; returns 1 when a result is due
  function automatic bit advance_flock(in_item_t it, output out_item_t res);
    longint p[3], v[3];
    p = '{longint'(it.pos_x), longint'(it.pos_y), longint'(it.pos_z)};
    v = '{longint'(it.vel_x), longint'(it.vel_y), longint'(it.vel_z)};
    res = '0;
    if (it.op == OP_OWN) begin
      boid_pos = p;
      boid_vel = v;
      boid_keys = {it.key_boost, it.key_down, it.key_up};
      drop_group();
    end else if (nb_count < MAX_NEIGHBOURS) begin
      absorb_neighbour(p, v);
    end
    if (it.last) begin
      res = steer_boid();
      drop_group();
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Result checker: results cannot be stalled, so sample every rising edge
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid) begin
      n_results++;
      if (pending_updates.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("ERROR: unexpected update %p", out_item);
      end else begin
        want = pending_updates.pop_front();
        if (out_item !== want) begin
          n_errors++;
          if (n_errors <= 10) begin
            $display("ERROR: update mismatch at cycle %0d", cycles);
            $display("  pos exp %h %h %h got %h %h %h", want.new_pos_x, want.new_pos_y,
                     want.new_pos_z, out_item.new_pos_x, out_item.new_pos_y, out_item.new_pos_z);
            $display("  vel exp %h %h %h got %h %h %h", want.new_vel_x, want.new_vel_y,
                     want.new_vel_z, out_item.new_vel_x, out_item.new_vel_y, out_item.new_vel_z);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("ERROR: timeout with %0d updates outstanding", pending_updates.size());
      $display("FAILURE");
      $finish;
    end
  end

  // Present one item at a falling edge and hold it until accepted
  task automatic send_item(in_item_t it, bit typed, out_item_t typed_res);
    int gap;
    out_item_t res;
    gap = $urandom_range(0, 6);
    if (gap != 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_item = it;
    start = 1'b1;
    do @(posedge clk); while (busy);
    if (!(it.op == OP_NEIGHBOUR && nb_count >= MAX_NEIGHBOURS)) n_items++;
    if (advance_flock(it, res)) begin
      expect_update(typed ? typed_res : res);
      n_groups++;
    end
    @(negedge clk);
  endtask

  task automatic drain();
    start = 1'b0;
    while (pending_updates.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_ALIGNMENT_GAIN:  gain_align = val;
      REG_SEPARATION_GAIN: gain_sep = val;
      REG_COHESION_GAIN:   gain_coh = val;
      REG_SPACE_RADIUS:    radius = val;
      REG_CRUISE_SPEED:    speed_cruise = val;
      REG_BOOST_SPEED:     speed_boost = val;
      default: ;
    endcase
  endtask

  function automatic in_item_t make_item(logic op, logic [31:0] px, logic [31:0] py,
                                         logic [31:0] pz, logic [31:0] vx, logic [31:0] vy,
                                         logic [31:0] vz, logic last, logic [2:0] keys);
    in_item_t it;
    it.op = op;
    it.pos_x = px;
    it.pos_y = py;
    it.pos_z = pz;
    it.vel_x = vx;
    it.vel_y = vy;
    it.vel_z = vz;
    it.last = last;
    {it.key_boost, it.key_down, it.key_up} = keys;
    return it;
  endfunction

  // Signed Q16.16 value spread over +/- span whole units
  function automatic logic [31:0] q_around(int span);
    return 32'($urandom_range(0, 2 * span * 65536)) - 32'(span * 65536);
  endfunction

  // One boid group: own record (unless dropped), then neighbours around it
  task automatic send_group(int n_nb, bit skip_own, bit wild);
    in_item_t it;
    logic [31:0] cx, cy, cz;
    cx = wild ? $urandom : q_around(600);
    cy = wild ? $urandom : q_around(600);
    cz = wild ? $urandom : q_around(600);
    if (!skip_own) begin
      it = make_item(OP_OWN, cx, cy, cz, q_around(4), q_around(4), q_around(4), n_nb == 0,
                     3'($urandom));
      if (wild) it = make_item(OP_OWN, cx, cy, cz, $urandom, $urandom, $urandom, n_nb == 0,
                               3'($urandom));
      send_item(it, 1'b0, '0);
    end else begin
      cx = boid_pos[0][31:0];
      cy = boid_pos[1][31:0];
      cz = boid_pos[2][31:0];
    end
    for (int k = 0; k < n_nb; k++) begin
      if ($urandom_range(0, 19) == 0)
        it = make_item(OP_NEIGHBOUR, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                       k == n_nb - 1, 3'($urandom));
      else if ($urandom_range(0, 15) == 0)
        it = make_item(OP_NEIGHBOUR, cx, cy, cz, q_around(4), q_around(4), q_around(4),
                       k == n_nb - 1, 3'($urandom));
      else
        it = make_item(OP_NEIGHBOUR, cx + q_around(14), cy + q_around(14), cz + q_around(14),
                       q_around(4), q_around(4), q_around(4), k == n_nb - 1, 3'($urandom));
      send_item(it, 1'b0, '0);
    end
  endtask

  typedef struct {
    in_item_t item;
    bit typed;
    out_item_t res;
  } stim_row_t;

  initial begin
    stim_row_t rows[$];
    stim_row_t row;
    in_item_t it;
    int goal;
    int sel;

    reset_flock();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed table, registers at reset values
    row.typed = 1'b1;
    row.item = make_item(OP_OWN, 0, 0, 0, 0, 0, 0, 1'b1, 3'b000);
    row.res = '0;
    rows = {rows, row};
    row.item = make_item(OP_OWN, 0, 0, 0, 32'h0001_0000, 0, 0, 1'b1, 3'b000);
    row.res = '{32'h0001_0000, 0, 0, 32'h0001_0000, 0, 0};
    rows = {rows, row};
    row.item = make_item(OP_OWN, 0, 0, 0, 0, 32'h0003_0000, 0, 1'b1, 3'b100);
    row.res = '{0, 32'h0002_0000, 0, 0, 32'h0002_0000, 0};
    rows = {rows, row};
    row.item = make_item(OP_OWN, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                         32'h0001_0000, 0, 0, 1'b1, 3'b000);
    row.res = '{32'h0200_0000, 32'h0200_0000, 32'h0200_0000, 32'h0001_0000, 0, 0};
    rows = {rows, row};
    row.item = make_item(OP_OWN, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                         0, 0, 32'hffff_0000, 1'b1, 3'b000);
    row.res = '{32'hfe00_0000, 32'hfe00_0000, 32'hfe00_0000, 0, 0, 32'hffff_0000};
    rows = {rows, row};
    row.typed = 1'b0;
    row.res = '0;
    row.item = make_item(OP_OWN, 0, 0, 0, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                         1'b1, 3'b000);
    rows = {rows, row};
    // Group with up key: near, coincident and far neighbours
    row.item = make_item(OP_OWN, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                         32'h0001_0000, 0, 0, 1'b0, 3'b001);
    rows = {rows, row};
    row.item = make_item(OP_NEIGHBOUR, 32'h0002_0000, 32'h0002_0000, 32'h0003_0000,
                         0, 32'h0001_0000, 0, 1'b0, 3'b000);
    rows = {rows, row};
    row.item = make_item(OP_NEIGHBOUR, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                         0, 0, 32'h0001_0000, 1'b0, 3'b000);
    rows = {rows, row};
    row.item = make_item(OP_NEIGHBOUR, 32'h0064_0000, 32'h0064_0000, 32'h0064_0000,
                         0, 0, 0, 1'b1, 3'b000);
    rows = {rows, row};
    // Down key with an extreme neighbour
    row.item = make_item(OP_OWN, 0, 0, 0, 0, 0, 32'h0001_0000, 1'b0, 3'b010);
    rows = {rows, row};
    row.item = make_item(OP_NEIGHBOUR, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                         32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 1'b1, 3'b111);
    rows = {rows, row};
    // Neighbour with no fresh own record reuses the stored one
    row.item = make_item(OP_NEIGHBOUR, 32'h0000_8000, 0, 0, 32'h0001_0000, 0, 0, 1'b1, 3'b000);
    rows = {rows, row};
    // Own record in mid-group restarts the group
    row.item = make_item(OP_OWN, 32'h0005_0000, 32'h0005_0000, 32'h0005_0000,
                         32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 1'b0, 3'b000);
    rows = {rows, row};
    row.item = make_item(OP_NEIGHBOUR, 32'h0006_0000, 32'h0005_0000, 32'h0005_0000,
                         0, 0, 0, 1'b0, 3'b000);
    rows = {rows, row};
    row.item = make_item(OP_OWN, 0, 0, 0, 0, 32'h0001_0000, 0, 1'b0, 3'b111);
    rows = {rows, row};
    row.item = make_item(OP_NEIGHBOUR, 32'h0001_0000, 0, 0, 0, 0, 0, 1'b1, 3'b000);
    rows = {rows, row};

    foreach (rows[r]) send_item(rows[r].item, rows[r].typed, rows[r].res);
    // Overflow the neighbour limit; the extra records are dropped but last still ends it
    send_group(MAX_NEIGHBOURS + 2, 1'b0, 1'b0);
    drain();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: for (int r = 0; r < 6; r++) write_reg(CFG_IDX_W'(r), '1);
        1: for (int r = 0; r < 6; r++) write_reg(CFG_IDX_W'(r), '0);
        2: begin
          write_reg(REG_ALIGNMENT_GAIN, '1);
          write_reg(REG_SEPARATION_GAIN, 31'($urandom_range(0, 4 * 65536)));
          write_reg(REG_COHESION_GAIN, '0);
          write_reg(REG_SPACE_RADIUS, 31'($urandom_range(0, 3 * 65536)));
          write_reg(REG_CRUISE_SPEED, '1);
          write_reg(REG_BOOST_SPEED, '0);
        end
        default: begin
          write_reg(REG_ALIGNMENT_GAIN, 31'($urandom_range(0, 4 * 65536)));
          write_reg(REG_SEPARATION_GAIN, 31'($urandom_range(0, 4 * 65536)));
          write_reg(REG_COHESION_GAIN, 31'($urandom_range(0, 4 * 65536)));
          write_reg(REG_SPACE_RADIUS, 31'($urandom_range(0, 40 * 65536)));
          write_reg(REG_CRUISE_SPEED, 31'($urandom_range(0, 8 * 65536)));
          write_reg(REG_BOOST_SPEED, 31'($urandom_range(0, 8 * 65536)));
        end
      endcase
      goal = n_items + RANDOM_ITEMS / NUM_PHASES;
      while (n_items < goal) begin
        sel = $urandom_range(0, 99);
        if (sel < 8) begin
          it = make_item(1'($urandom), $urandom, $urandom, $urandom, $urandom, $urandom,
                         $urandom, 1'($urandom), 3'($urandom));
          send_item(it, 1'b0, '0);
        end else if (sel < 10) begin
          send_group($urandom_range(60, 68), 1'b0, 1'b0);
        end else begin
          send_group($urandom_range(0, 6), sel < 15, sel < 22);
        end
        // Let the block run dry now and then so no-gap stretches meet idle ones
        if ($urandom_range(0, 29) == 0) drain();
      end
      drain();
    end

    $display("Covered %0d items in %0d groups, %0d updates checked, over %0d register settings",
             n_items, n_groups, n_results, NUM_PHASES + 1);
    if (n_errors == 0 && pending_updates.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("Mismatches: %0d, missing updates: %0d", n_errors, pending_updates.size());
      $display("FAILURE");
    end
    $finish;
  end

endmodule
